[rtl/pit_pkg.sv]
// Package for the interval timer: item types, command codes and per-counter op bundle.
package pit_pkg;

    localparam logic [1:0] CMD_WR   = 2'd0;
    localparam logic [1:0] CMD_RD   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_GATE = 2'd3;

    localparam logic [1:0] PORT_CTRL = 2'd3;
    localparam logic [1:0] RB_CODE   = 2'b11;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] port;
        logic [7:0] wdata;
        logic [1:0] counter_sel;
        logic       gate_level;
    } t_in_item;

    typedef struct packed {
        logic [7:0] rdata;
        logic       out0;
        logic       out1;
        logic       out2;
    } t_out_item;

    typedef struct packed {
        logic ctrl;
        logic rb;
        logic wr;
        logic rd;
        logic tick;
        logic gate;
    } t_cnt_op;

endpackage

[rtl/pit_counter.sv]
// One timer counter: state registers and single-pass next-state logic.
module pit_counter import pit_pkg::*; #(
    parameter logic [1:0] IDX = 2'd0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  t_cnt_op    i_op,
    input  logic [7:0] i_byte,
    input  logic       i_gate_level,
    output logic [7:0] o_rdata,
    output logic       o_out_nxt
);

    logic [15:0] r_reload, n_reload;
    logic [16:0] r_down, n_down;
    logic [2:0]  r_mode, n_mode;
    logic [1:0]  r_rorder, n_rorder;
    logic [1:0]  r_worder, n_worder;
    logic [15:0] r_latch, n_latch;
    logic [7:0]  r_ctrl, n_ctrl;
    logic [7:0]  r_status, n_status;
    logic r_gate, n_gate, r_out, n_out, r_thit, n_thit, r_en, n_en, r_dis, n_dis;
    logic r_init, n_init, r_newc, n_newc, r_latched, n_latched;
    logic r_reread, n_reread, r_stat, n_stat;

    always_comb begin
        logic [15:0]        live;
        logic [2:0]         m;
        logic               do_load;
        logic signed [17:0] l;
        logic signed [17:0] d;
        logic               rise;
        logic [17:0]        half_up;

        n_reload = r_reload; n_down = r_down; n_mode = r_mode;
        n_rorder = r_rorder; n_worder = r_worder; n_latch = r_latch;
        n_ctrl = r_ctrl; n_status = r_status;
        n_gate = r_gate; n_out = r_out; n_thit = r_thit; n_en = r_en; n_dis = r_dis;
        n_init = r_init; n_newc = r_newc; n_latched = r_latched;
        n_reread = r_reread; n_stat = r_stat;
        o_rdata = 8'hFF;
        do_load = 1'b0;
        m = 3'd0;
        rise = 1'b0;
        half_up = 18'd0;
        d = 18'sd0;

        live = r_down[15:0] + ((r_mode == 3'd2) ? 16'd1 : 16'd0);

        if (i_op.ctrl) begin
            if (i_byte[5:4] == 2'b00) begin
                n_latch = live;
                n_reread = 1'b0;
                n_rorder = 2'd3;
                n_latched = 1'b1;
            end else begin
                m = i_byte[3:1];
                if (m > 3'd5) m = {1'b0, m[1:0]};
                n_ctrl = i_byte;
                n_rorder = i_byte[5:4];
                n_worder = i_byte[5:4];
                n_mode = m;
                n_reread = 1'b1;
                n_init = 1'b1;
                n_out = (m != 3'd0);
                n_dis = 1'b1;
            end
            n_thit = 1'b0;
        end

        if (i_op.rb) begin
            if (!i_byte[5]) n_latch = live;
            if (!i_byte[4]) begin
                n_status = {r_out, 1'b0, r_ctrl[5:0]};
                n_stat = 1'b1;
            end
        end

        if (i_op.wr) begin
            unique case (r_worder)
                2'd1: begin n_reload = {8'h00, i_byte}; do_load = 1'b1; end
                2'd2: begin n_reload = {i_byte, 8'h00}; do_load = 1'b1; end
                2'd0: begin
                    n_reload = {i_byte, r_reload[7:0]};
                    do_load = 1'b1;
                    n_worder = 2'd3;
                end
                default: begin
                    n_reload = {r_reload[15:8], i_byte};
                    n_worder = 2'd0;
                end
            endcase
        end

        l = (n_reload == 16'd0) ? 18'sh10000 : signed'({2'b00, n_reload});

        if (do_load) begin
            n_newc = 1'b0;
            n_dis = 1'b0;
            unique case (r_mode)
                3'd0: begin
                    n_down = l[16:0]; n_out = 1'b0; n_thit = 1'b0; n_en = r_gate;
                end
                3'd2: begin
                    if (r_init) begin
                        d = l - 18'sd1;
                        n_down = d[16:0]; n_out = 1'b1; n_thit = 1'b0;
                    end
                    n_en = r_gate;
                end
                3'd3: begin
                    if (r_init) begin n_down = l[16:0]; n_out = 1'b1; n_thit = 1'b0; end
                    n_en = r_gate;
                end
                3'd4: begin
                    if (!r_thit && !r_init) n_newc = 1'b1;
                    else begin n_down = l[16:0]; n_out = 1'b0; n_thit = 1'b0; end
                    n_en = r_gate;
                end
                default: n_en = 1'b1;
            endcase
            n_init = 1'b0;
        end

        if (i_op.rd) begin
            if (r_stat) begin
                n_stat = 1'b0;
                o_rdata = r_status;
            end else begin
                if (r_reread && !r_latched) begin
                    n_reread = 1'b0;
                    n_latch = live;
                end
                unique case (r_rorder)
                    2'd0: begin
                        o_rdata = n_latch[15:8]; n_rorder = 2'd3;
                        n_latched = 1'b0; n_reread = 1'b1;
                    end
                    2'd1: begin
                        o_rdata = n_latch[7:0]; n_latched = 1'b0; n_reread = 1'b1;
                    end
                    2'd2: begin
                        o_rdata = n_latch[15:8]; n_latched = 1'b0; n_reread = 1'b1;
                    end
                    default: begin
                        o_rdata = n_latch[7:0]; n_rorder = 2'd0;
                    end
                endcase
            end
        end

        if (i_op.tick && !r_thit && r_en) begin
            d = signed'({1'b0, r_down}) - ((r_mode == 3'd3) ? 18'sd2 : 18'sd1);
            if (d <= 18'sd0) begin
                if (r_dis) begin
                    d = d + 18'sh0FFFF;
                end else begin
                    unique case (r_mode)
                        3'd0, 3'd1, 3'd5: begin
                            if (!r_thit) n_out = 1'b1;
                            n_thit = 1'b1;
                            d = d + 18'sh0FFFF;
                        end
                        3'd2: begin d = d + l; n_out = 1'b1; end
                        3'd3: begin
                            half_up = unsigned'(l) + 18'd1;
                            if (r_out) begin
                                n_out = 1'b0;
                                d = d + signed'({1'b0, l[17:1]});
                            end else begin
                                n_out = 1'b1;
                                d = d + signed'({1'b0, half_up[17:1]});
                            end
                        end
                        default: begin
                            if (!r_thit) n_out = 1'b1;
                            if (r_newc) begin n_newc = 1'b0; d = d + l; end
                            else begin n_thit = 1'b1; d = d + 18'sh0FFFF; end
                        end
                    endcase
                end
                if (d < 18'sd0) d = 18'sd0;
            end
            n_down = d[16:0];
        end

        if (i_op.gate) begin
            rise = i_gate_level && !r_gate;
            if (!r_dis) begin
                unique case (r_mode)
                    3'd1, 3'd5: begin
                        if (rise) begin
                            n_down = l[16:0]; n_out = 1'b0; n_thit = 1'b0; n_en = 1'b1;
                        end
                    end
                    3'd2: begin
                        if (rise) begin
                            d = l - 18'sd1;
                            n_down = d[16:0]; n_out = 1'b1; n_thit = 1'b0;
                        end
                        n_en = i_gate_level;
                    end
                    3'd3: begin
                        if (rise) begin n_down = l[16:0]; n_out = 1'b1; n_thit = 1'b0; end
                        n_en = i_gate_level;
                    end
                    default: n_en = i_gate_level;
                endcase
            end
            n_gate = i_gate_level;
        end
    end

    assign o_out_nxt = n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= 16'hFFFF; r_down <= '0; r_mode <= '0;
            r_rorder <= '0; r_worder <= '0; r_latch <= '0;
            r_ctrl <= '0; r_status <= '0;
            r_gate <= (IDX < 2'd2); r_out <= 1'b0; r_thit <= (IDX == 2'd0);
            r_en <= 1'b0; r_dis <= 1'b0; r_init <= 1'b0; r_newc <= 1'b0;
            r_latched <= 1'b0; r_reread <= 1'b0; r_stat <= 1'b0;
        end else if (i_go) begin
            r_reload <= n_reload; r_down <= n_down; r_mode <= n_mode;
            r_rorder <= n_rorder; r_worder <= n_worder; r_latch <= n_latch;
            r_ctrl <= n_ctrl; r_status <= n_status;
            r_gate <= n_gate; r_out <= n_out; r_thit <= n_thit;
            r_en <= n_en; r_dis <= n_dis; r_init <= n_init; r_newc <= n_newc;
            r_latched <= n_latched; r_reread <= n_reread; r_stat <= n_stat;
        end
    end

endmodule

[rtl/programmable_interval_timer_top.sv]
// Interval timer top level: input register, op decode, counters, result register.
// Takes one item per cycle (bus write, bus read, tick or gate change) and returns one
// result per item: the accepted item is registered in the input register, then
// decoded and applied to the addressed counter's state in one pass while the result
// register captures read data and all OUT levels. Throughput is one item per cycle;
// the input stalls only while both registers hold items and the result is not taken.
module programmable_interval_timer_top import pit_pkg::*; #(
    parameter int NUM_COUNTERS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_res_valid;
    t_out_item r_res;
    logic [7:0] r_last_ctrl, n_last_ctrl;

    logic pipe_go, go;
    t_cnt_op   op [3];
    logic [7:0] cnt_rdata [3];
    logic [2:0] out_nxt;
    logic [7:0] rdata;

    assign pipe_go    = !r_res_valid || !i_out_stall;
    assign go         = r_in_valid && pipe_go;
    assign o_in_stall = r_in_valid && !pipe_go;

    always_comb begin
        n_last_ctrl = r_last_ctrl;
        for (int i = 0; i < 3; i++) begin
            op[i] = '0;
            if (r_in.cmd == CMD_WR && r_in.port == PORT_CTRL) begin
                if (r_in.wdata[7:6] == RB_CODE) op[i].rb = r_in.wdata[i + 1];
                else op[i].ctrl = (r_in.wdata[7:6] == 2'(i));
            end
            op[i].wr   = (r_in.cmd == CMD_WR) && (r_in.port == 2'(i));
            op[i].rd   = (r_in.cmd == CMD_RD) && (r_in.port == 2'(i));
            op[i].tick = (r_in.cmd == CMD_TICK) && (r_in.counter_sel == 2'(i));
            op[i].gate = (r_in.cmd == CMD_GATE) && (r_in.counter_sel == 2'(i));
        end
        if (r_in.cmd == CMD_WR && r_in.port == PORT_CTRL && r_in.wdata[7:6] != RB_CODE) begin
            n_last_ctrl = r_in.wdata;
            if (int'(r_in.wdata[7:6]) < NUM_COUNTERS && r_in.wdata[5:4] == 2'b00)
                n_last_ctrl = r_in.wdata | 8'h30;
        end
        rdata = 8'hFF;
        if (r_in.cmd == CMD_RD) begin
            if (r_in.port == PORT_CTRL) rdata = r_last_ctrl;
            else rdata = cnt_rdata[r_in.port];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_cnt
        if (g < NUM_COUNTERS) begin : g_on
            pit_counter #(.IDX(2'(g))) u_cnt (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_go         (go),
                .i_op         (op[g]),
                .i_byte       (r_in.wdata),
                .i_gate_level (r_in.gate_level),
                .o_rdata      (cnt_rdata[g]),
                .o_out_nxt    (out_nxt[g])
            );
        end else begin : g_off
            assign cnt_rdata[g] = 8'hFF;
            assign out_nxt[g]   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_res_valid <= 1'b0;
            r_last_ctrl <= '0;
        end else begin
            if (!o_in_stall) r_in_valid <= i_in_valid;
            if (pipe_go) r_res_valid <= r_in_valid;
            if (go) r_last_ctrl <= n_last_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) r_in <= i_in;
        if (go) r_res <= '{rdata: rdata, out0: out_nxt[0], out1: out_nxt[1], out2: out_nxt[2]};
    end

    assign o_out_valid = r_res_valid;
    assign o_out       = r_res;

endmodule

[rtl/pit_checker.sv]
// Port-level checker for the interval timer, bound to the top level.
module pit_checker import pit_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("stalled result item changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled with output side free");

    a_reset_clear: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

endmodule

bind programmable_interval_timer_top pit_checker u_pit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[tb/sv/programmable_interval_timer_top_tb.sv]
// Testbench for the interval timer: random and directed bus, tick and gate items, scoreboarded.
`timescale 1ns / 1ps

module programmable_interval_timer_top_tb;
    import pit_pkg::*;

    localparam int NCNT = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IN_W = $bits(t_in_item);

    localparam logic [9:0] FL_GATE    = 10'h001;
    localparam logic [9:0] FL_OUT     = 10'h002;
    localparam logic [9:0] FL_THIT    = 10'h004;
    localparam logic [9:0] FL_EN      = 10'h008;
    localparam logic [9:0] FL_DIS     = 10'h010;
    localparam logic [9:0] FL_INIT    = 10'h020;
    localparam logic [9:0] FL_NEWC    = 10'h040;
    localparam logic [9:0] FL_LATCHED = 10'h080;
    localparam logic [9:0] FL_REREAD  = 10'h100;
    localparam logic [9:0] FL_STAT    = 10'h200;

    class timer_scoreboard;
        logic [15:0] reload [NCNT];
        int          count [NCNT];
        logic [2:0]  mode [NCNT];
        logic [1:0]  rd_ord [NCNT];
        logic [1:0]  wr_ord [NCNT];
        logic [15:0] latch [NCNT];
        logic [7:0]  ctl [NCNT];
        logic [7:0]  stat [NCNT];
        logic [9:0]  fl [NCNT];
        logic [7:0]  last_ctl;
        t_out_item   pending[$];
        int          mismatches;

        function new();
            mismatches = 0;
            for (int i = 0; i < NCNT; i++) begin
                reload[i] = 16'hFFFF;
                count[i] = 0;
                mode[i] = '0;
                rd_ord[i] = '0;
                wr_ord[i] = '0;
                latch[i] = '0;
                ctl[i] = '0;
                stat[i] = '0;
                fl[i] = (i < 2 ? FL_GATE : 10'h0) | (i == 0 ? FL_THIT : 10'h0);
            end
            last_ctl = '0;
        endfunction

        function bit has(int t, logic [9:0] b);
            return (fl[t] & b) != 0;
        endfunction

        function void put(int t, logic [9:0] b, bit v);
            if (v) fl[t] |= b;
            else fl[t] &= ~b;
        endfunction

        function int period(int t);
            return reload[t] != 0 ? int'(reload[t]) : 32'h10000;
        endfunction

        function logic [15:0] live(int t);
            int v;
            v = count[t] + (mode[t] == 2 ? 1 : 0);
            return v[15:0];
        endfunction

        function void load(int t);
            int l;
            bit g;
            bit ini;
            l = period(t);
            g = has(t, FL_GATE);
            ini = has(t, FL_INIT);
            put(t, FL_NEWC, 0);
            put(t, FL_DIS, 0);
            case (mode[t])
                0: begin
                    count[t] = l; put(t, FL_OUT, 0); put(t, FL_THIT, 0); put(t, FL_EN, g);
                end
                2: begin
                    if (ini) begin
                        count[t] = l - 1; put(t, FL_OUT, 1); put(t, FL_THIT, 0);
                    end
                    put(t, FL_EN, g);
                end
                3: begin
                    if (ini) begin
                        count[t] = l; put(t, FL_OUT, 1); put(t, FL_THIT, 0);
                    end
                    put(t, FL_EN, g);
                end
                4: begin
                    if (!has(t, FL_THIT) && !ini) put(t, FL_NEWC, 1);
                    else begin
                        count[t] = l; put(t, FL_OUT, 0); put(t, FL_THIT, 0);
                    end
                    put(t, FL_EN, g);
                end
                default: put(t, FL_EN, 1);
            endcase
            put(t, FL_INIT, 0);
        endfunction

        function void gate(int t, bit g);
            int l;
            bit rise;
            l = period(t);
            rise = g && !has(t, FL_GATE);
            if (!has(t, FL_DIS)) begin
                case (mode[t])
                    1, 5: if (rise) begin
                        count[t] = l; put(t, FL_OUT, 0); put(t, FL_THIT, 0); put(t, FL_EN, 1);
                    end
                    2: begin
                        if (rise) begin
                            count[t] = l - 1; put(t, FL_OUT, 1); put(t, FL_THIT, 0);
                        end
                        put(t, FL_EN, g);
                    end
                    3: begin
                        if (rise) begin
                            count[t] = l; put(t, FL_OUT, 1); put(t, FL_THIT, 0);
                        end
                        put(t, FL_EN, g);
                    end
                    default: put(t, FL_EN, g);
                endcase
            end
            put(t, FL_GATE, g);
        endfunction

        function void expire(int t);
            int l;
            l = period(t);
            if (has(t, FL_DIS)) count[t] += 32'hFFFF;
            else begin
                case (mode[t])
                    0, 1, 5: begin
                        if (!has(t, FL_THIT)) put(t, FL_OUT, 1);
                        put(t, FL_THIT, 1);
                        count[t] += 32'hFFFF;
                    end
                    2: begin
                        count[t] += l; put(t, FL_OUT, 1);
                    end
                    3: begin
                        if (has(t, FL_OUT)) begin
                            put(t, FL_OUT, 0); count[t] += l >>> 1;
                        end else begin
                            put(t, FL_OUT, 1); count[t] += (l + 1) >>> 1;
                        end
                    end
                    default: begin
                        if (!has(t, FL_THIT)) put(t, FL_OUT, 1);
                        if (has(t, FL_NEWC)) begin
                            put(t, FL_NEWC, 0); count[t] += l;
                        end else begin
                            put(t, FL_THIT, 1); count[t] += 32'hFFFF;
                        end
                    end
                endcase
            end
            if (count[t] < 0) count[t] = 0;
        endfunction

        function void tick(int t);
            if (has(t, FL_THIT) || !has(t, FL_EN)) return;
            count[t] -= (mode[t] == 3) ? 2 : 1;
            if (count[t] <= 0) expire(t);
        endfunction

        function void control(logic [7:0] v);
            int t;
            logic [2:0] m;
            if (v[7:6] == RB_CODE) begin
                for (int i = 0; i < NCNT; i++) begin
                    if (v[i + 1]) begin
                        if (!v[5]) latch[i] = live(i);
                        if (!v[4]) begin
                            stat[i] = {has(i, FL_OUT), 1'b0, ctl[i][5:0]};
                            put(i, FL_STAT, 1);
                        end
                    end
                end
                return;
            end
            t = int'(v[7:6]);
            last_ctl = v;
            if (t >= NCNT) return;
            if (v[5:4] == 2'b00) begin
                latch[t] = live(t);
                last_ctl = v | 8'h30;
                put(t, FL_REREAD, 0);
                rd_ord[t] = 2'd3;
                put(t, FL_LATCHED, 1);
            end else begin
                m = v[3:1];
                if (m > 3'd5) m &= 3'd3;
                ctl[t] = v;
                rd_ord[t] = v[5:4];
                wr_ord[t] = v[5:4];
                mode[t] = m;
                put(t, FL_REREAD, 1);
                put(t, FL_INIT, 1);
                put(t, FL_OUT, m != 0);
                put(t, FL_DIS, 1);
            end
            put(t, FL_THIT, 0);
        endfunction

        function void data_write(int t, logic [7:0] v);
            case (wr_ord[t])
                2'd1: begin reload[t] = {8'h00, v}; load(t); end
                2'd2: begin reload[t] = {v, 8'h00}; load(t); end
                2'd0: begin reload[t] = {v, reload[t][7:0]}; load(t); wr_ord[t] = 2'd3; end
                default: begin reload[t] = {reload[t][15:8], v}; wr_ord[t] = 2'd0; end
            endcase
        endfunction

        function logic [7:0] data_read(int t);
            logic [7:0] r;
            if (has(t, FL_STAT)) begin
                put(t, FL_STAT, 0);
                return stat[t];
            end
            if (has(t, FL_REREAD) && !has(t, FL_LATCHED)) begin
                put(t, FL_REREAD, 0);
                latch[t] = live(t);
            end
            case (rd_ord[t])
                2'd0: begin
                    r = latch[t][15:8]; rd_ord[t] = 2'd3;
                    put(t, FL_LATCHED, 0); put(t, FL_REREAD, 1);
                end
                2'd1: begin
                    r = latch[t][7:0]; put(t, FL_LATCHED, 0); put(t, FL_REREAD, 1);
                end
                2'd2: begin
                    r = latch[t][15:8]; put(t, FL_LATCHED, 0); put(t, FL_REREAD, 1);
                end
                default: begin
                    r = latch[t][7:0]; rd_ord[t] = 2'd0;
                end
            endcase
            return r;
        endfunction

        function void note_item(t_in_item it);
            t_out_item e;
            e.rdata = 8'hFF;
            case (it.cmd)
                CMD_WR: begin
                    if (it.port == PORT_CTRL) control(it.wdata);
                    else if (it.port < NCNT) data_write(int'(it.port), it.wdata);
                end
                CMD_RD: begin
                    if (it.port == PORT_CTRL) e.rdata = last_ctl;
                    else if (it.port < NCNT) e.rdata = data_read(int'(it.port));
                end
                CMD_TICK: if (it.counter_sel < NCNT) tick(int'(it.counter_sel));
                default: if (it.counter_sel < NCNT) gate(int'(it.counter_sel), it.gate_level);
            endcase
            e.out0 = has(0, FL_OUT);
            e.out1 = has(1, FL_OUT);
            e.out2 = has(2, FL_OUT);
            pending.push_back(e);
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.rdata !== e.rdata || got.out0 !== e.out0 || got.out1 !== e.out1
                    || got.out2 !== e.out2) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected rdata %h out %b%b%b, got rdata %h out %b%b%b",
                             e.rdata, e.out0, e.out1, e.out2,
                             got.rdata, got.out0, got.out1, got.out2);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;

    timer_scoreboard sb;
    int  cycles = 0;
    bit  no_idle = 0;
    int  hold_cycles = 0;

    programmable_interval_timer_top #(.NUM_COUNTERS(NCNT)) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(in_stall),
        .i_in(in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out(out_item)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && !in_stall) sb.note_item(in_item);
        if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold while the sender keeps offering
    initial begin
        int n;
        bit held;
        held = 0;
        out_stall = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_cycles > 0 && !held) begin
                out_stall = 1;
                repeat (hold_cycles) @(negedge clk);
                held = 1;
                out_stall = 0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 18);
                out_stall = 1;
                repeat (n) @(negedge clk);
                out_stall = 0;
            end else begin
                out_stall = 0;
            end
        end
    end

    task automatic send(t_in_item it);
        int n;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            in_valid = 0;
            n = $urandom_range(1, 18);
            repeat (n) @(negedge clk);
        end
        in_item = it;
        in_valid = 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 0;
    endtask

    task automatic send_fields(logic [1:0] c, logic [1:0] p, logic [7:0] w,
                               logic [1:0] s, logic g);
        t_in_item it;
        it.cmd = c;
        it.port = p;
        it.wdata = w;
        it.counter_sel = s;
        it.gate_level = g;
        send(it);
    endtask

    task automatic drain();
        in_valid = 0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    // well-formed program: control word, reload bytes, ticks, gates, reads, latches, read-backs
    task automatic random_program();
        logic [1:0] t;
        logic [7:0] cw;
        int nt;
        t = 2'($urandom_range(0, 2));
        cw = {t, 2'($urandom_range(1, 3)), 3'($urandom), 1'($urandom)};
        send_fields(CMD_WR, PORT_CTRL, cw, 2'd0, 1'b0);
        send_fields(CMD_WR, t, $urandom_range(0, 3) == 0 ? 8'($urandom) :
                    8'($urandom_range(0, 6)), 2'd0, 1'b0);
        if (cw[5:4] == 2'b11) send_fields(CMD_WR, t, $urandom_range(0, 3) == 0 ?
                                          8'($urandom) : 8'h00, 2'd0, 1'b0);
        nt = $urandom_range(3, 14);
        for (int k = 0; k < nt; k++) begin
            case ($urandom_range(0, 9))
                0: send_fields(CMD_GATE, 2'd0, 8'($urandom), t, 1'($urandom));
                1: send_fields(CMD_RD, t, 8'($urandom), 2'($urandom), 1'($urandom));
                2: send_fields(CMD_WR, PORT_CTRL, {2'b11, 6'($urandom)}, 2'd0, 1'b0);
                3: send_fields(CMD_WR, PORT_CTRL, {t, 6'($urandom_range(0, 1))}, 2'd0, 1'b0);
                default: send_fields(CMD_TICK, 2'($urandom), 8'($urandom), t, 1'($urandom));
            endcase
        end
    endtask

    initial begin
        t_in_item it;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        repeat (2) @(negedge clk);
        rst_n = 1;

        // directed: modes 1, 3, 4 and 5, byte orders, latch, read-back, absent counter, odd mode 3
        send_fields(CMD_RD, PORT_CTRL, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'h36, 2'd0, 1'b0);
        send_fields(CMD_WR, 2'd0, 8'h05, 2'd0, 1'b0);
        send_fields(CMD_WR, 2'd0, 8'h00, 2'd0, 1'b0);
        repeat (4) send_fields(CMD_TICK, 2'd0, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_RD, 2'd0, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_RD, 2'd0, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'h5E, 2'd0, 1'b0);
        send_fields(CMD_WR, 2'd1, 8'hFF, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'hB2, 2'd0, 1'b0);
        send_fields(CMD_WR, 2'd2, 8'h02, 2'd0, 1'b0);
        send_fields(CMD_GATE, 2'd0, 8'h00, 2'd2, 1'b1);
        send_fields(CMD_TICK, 2'd0, 8'h00, 2'd2, 1'b0);
        send_fields(CMD_GATE, 2'd0, 8'h00, 2'd2, 1'b0);
        send_fields(CMD_GATE, 2'd0, 8'h00, 2'd2, 1'b1);
        send_fields(CMD_WR, PORT_CTRL, 8'hC2, 2'd0, 1'b0);
        send_fields(CMD_RD, 2'd0, 8'h00, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'h7A, 2'd0, 1'b0);
        send_fields(CMD_WR, PORT_CTRL, 8'h98, 2'd0, 1'b0);
        send_fields(CMD_TICK, 2'd0, 8'h00, 2'd3, 1'b1);
        send_fields(CMD_GATE, 2'd0, 8'h00, 2'd3, 1'b1);
        send_fields(CMD_WR, PORT_CTRL, 8'hFF, 2'd0, 1'b0);
        send_fields(CMD_RD, PORT_CTRL, 8'h00, 2'd0, 1'b0);

        for (int p = 0; p < 20; p++) random_program();

        // block fills while the receiver holds
        hold_cycles = 60;
        for (int k = 0; k < 20; k++)
            send_fields(CMD_TICK, 2'd0, 8'($urandom), 2'($urandom), 1'b0);
        drain();

        for (int p = 0; p < 14; p++) random_program();
        for (int k = 0; k < 40; k++) begin
            it = t_in_item'(IN_W'($urandom));
            send(it);
        end
        drain();
        no_idle = 1;
        for (int p = 0; p < 6; p++) random_program();
        drain();
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
